// ----- src/sm4_pkg.sv -----
package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    // Cycles from an accepted start to its done strobe.
    localparam int LATENCY = NUM_ROUNDS + 1;

    localparam logic [7:0] AFFINE_ROW = 8'hA7;
    localparam logic [7:0] AFFINE_ADD = 8'hD3;
    localparam logic [7:0] FIELD_RED  = 8'hF5;

    // Four 32-bit words; index 0 is the oldest word of the round state.
    typedef logic [3:0][31:0] t_words;
    typedef logic [255:0][7:0] t_sbox_tbl;
    typedef logic [NUM_ROUNDS-1:0][31:0] t_ck_tbl;

    localparam t_words FK = {32'hb27022dc, 32'h677d9197, 32'h56aa3350, 32'ha3b1bac6};

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    function automatic logic [7:0] affine8(input logic [7:0] x);
        logic [7:0] acc;
        logic [7:0] row;
        acc = '0;
        row = AFFINE_ROW;
        for (int k = 0; k < 8; k++) begin
            acc = acc ^ {7'b0, ^(x & row)};
            acc = {acc[0], acc[7:1]};
            row = {row[6:0], row[7]};
        end
        return acc ^ AFFINE_ADD;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        a = a_in;
        b = b_in;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[0]) begin
                r = r ^ a;
            end
            b = b >> 1;
            a = a[7] ? ({a[6:0], 1'b0} ^ FIELD_RED) : {a[6:0], 1'b0};
        end
        return r;
    endfunction

    // x^254 in GF(2^8); zero maps to zero.
    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] result;
        logic [7:0] base;
        logic [7:0] e;
        result = 8'd1;
        base = x;
        e = 8'd254;
        for (int k = 0; k < 8; k++) begin
            if (e[0]) begin
                result = gf_mul(result, base);
            end
            base = gf_mul(base, base);
            e = e >> 1;
        end
        return (x != 8'd0) ? result : 8'd0;
    endfunction

    function automatic t_sbox_tbl build_sbox();
        t_sbox_tbl t;
        for (int i = 0; i < 256; i++) begin
            t[i] = affine8(gf_inv(affine8(8'(i))));
        end
        return t;
    endfunction

    function automatic t_ck_tbl build_ck();
        t_ck_tbl t;
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            t[i] = {8'((4 * i) * 7), 8'((4 * i + 1) * 7), 8'((4 * i + 2) * 7),
                    8'((4 * i + 3) * 7)};
        end
        return t;
    endfunction

    // Both tables are worked out at elaboration.
    localparam t_sbox_tbl SBOX = build_sbox();
    localparam t_ck_tbl CK = build_ck();

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic t_words key_round(input t_words k, input logic [31:0] ck);
        logic [31:0] b;
        logic [31:0] t;
        b = tau(k[1] ^ k[2] ^ k[3] ^ ck);
        t = k[0] ^ b ^ rotl32(b, 13) ^ rotl32(b, 23);
        return {t, k[3], k[2], k[1]};
    endfunction

    function automatic t_words data_round(input t_words x, input logic [31:0] rk);
        logic [31:0] b;
        logic [31:0] t;
        b = tau(x[1] ^ x[2] ^ x[3] ^ rk);
        t = x[0] ^ b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
        return {t, x[3], x[2], x[1]};
    endfunction

endpackage

// ----- src/sm4_stage.sv -----
module sm4_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sm4_pkg::t_words i_k,
    input  sm4_pkg::t_words i_x,
    input  logic [31:0]     i_ck,
    output logic            o_valid,
    output sm4_pkg::t_words o_k,
    output sm4_pkg::t_words o_x
);
    import sm4_pkg::*;

    logic   r_valid;
    t_words r_k;
    t_words r_x;
    t_words n_k;
    t_words n_x;

    // Key round j and data round j-1 run side by side; the newest key word
    // of the incoming state is the round key that the data round needs.
    always_comb begin
        n_k = key_round(i_k, i_ck);
        n_x = data_round(i_x, i_k[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_x <= n_x;
    end

    assign o_valid = r_valid;
    assign o_k     = r_k;
    assign o_x     = r_x;

endmodule

// ----- src/sm4_block_encrypt.sv -----
// SM4 block encryption engine, fully pipelined. A plaintext block is taken
// at every rising clock edge at which i_start is high; o_busy is always low,
// so a new block may follow in every cycle. Each block passes through 33
// register stages: the input stage runs the first key-schedule round, 31
// stages each run one key-schedule round next to one cipher round, and the
// output stage runs the last cipher round. The ciphertext appears on
// o_cipher_high and o_cipher_low for exactly one cycle with o_done high,
// in the order the blocks came in. The receiver cannot hold results off
// and must take each one when o_done is high. The key is written through
// the configuration port (index 0 for the upper half, index 1 for the
// lower half) and takes effect for the next block that is started; it
// must only be changed while no block is in flight.
module sm4_block_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    output logic        o_done,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low
);
    import sm4_pkg::*;

    // Key registers, written by the configuration port.
    logic [63:0] r_key_high;
    logic [63:0] r_key_low;

    // Input stage: key state after the first round, plaintext as taken.
    logic   r_in_valid;
    t_words r_in_k;
    t_words r_in_x;
    t_words n_in_k;
    t_words key_init;

    // Pipeline layers; layer j holds the key state after j+1 rounds and the
    // data state after j rounds.
    logic   w_valid [NUM_ROUNDS];
    t_words w_k     [NUM_ROUNDS];
    t_words w_x     [NUM_ROUNDS];

    // Output stage.
    logic        r_done;
    logic [63:0] r_cipher_high;
    logic [63:0] r_cipher_low;
    t_words      n_x_last;

    logic accept;

    // The pipeline never stalls, so a start transaction is always taken.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_high <= r_key_high;
            endcase
        end
    end

    // The key is whitened with FK and the first key-schedule round is done
    // before the input register.
    always_comb begin
        key_init = {r_key_low[31:0] ^ FK[3], r_key_low[63:32] ^ FK[2],
                    r_key_high[31:0] ^ FK[1], r_key_high[63:32] ^ FK[0]};
        n_in_k = key_round(key_init, CK[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_k <= n_in_k;
        r_in_x <= {i_plain_low[31:0], i_plain_low[63:32],
                   i_plain_high[31:0], i_plain_high[63:32]};
    end

    assign w_valid[0] = r_in_valid;
    assign w_k[0]     = r_in_k;
    assign w_x[0]     = r_in_x;

    // One stage per key round; each also runs the cipher round one behind.
    for (genvar j = 1; j < NUM_ROUNDS; j++) begin : g_round
        sm4_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[j-1]),
            .i_k     (w_k[j-1]),
            .i_x     (w_x[j-1]),
            .i_ck    (CK[j]),
            .o_valid (w_valid[j]),
            .o_k     (w_k[j]),
            .o_x     (w_x[j])
        );
    end

    // Last cipher round uses the final round key, then the words are
    // emitted in reversed order.
    always_comb begin
        n_x_last = data_round(w_x[NUM_ROUNDS-1], w_k[NUM_ROUNDS-1][3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_valid[NUM_ROUNDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cipher_high <= {n_x_last[3], n_x_last[2]};
        r_cipher_low  <= {n_x_last[1], n_x_last[0]};
    end

    assign o_done        = r_done;
    assign o_cipher_high = r_cipher_high;
    assign o_cipher_low  = r_cipher_low;

    // Every accepted block comes out after the full pipeline latency.
    a_start_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("started block did not complete after the pipeline latency");

    // No done strobe without a matching start transaction.
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("done strobe without a matching start transaction");

    // The valid bit of the last layer lines up with the input stage.
    a_layer_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> ##(NUM_ROUNDS-1) w_valid[NUM_ROUNDS-1])
        else $error("valid bit lost inside the round pipeline");

endmodule
